>>> hdl/ntta_pkg.sv
// Package for the neighbor table with TTL aging.
// Holds sizes, command and event codes, and the table entry type.
// No dependencies.
package ntta_pkg;
  localparam int unsigned ENTRIES = 32;
  localparam int unsigned SLOT_W  = $clog2(ENTRIES);
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);

  localparam logic [1:0] CMD_FRAME  = 2'd0;
  localparam logic [1:0] CMD_EXPIRE = 2'd1;
  localparam logic [1:0] CMD_FLUSH  = 2'd2;

  localparam logic [1:0] EV_ADDED     = 2'd0;
  localparam logic [1:0] EV_REMOVED   = 2'd1;
  localparam logic [1:0] EV_UPDATED   = 2'd2;
  localparam logic [1:0] EV_REFRESHED = 2'd3;

  localparam logic [1:0] REG_MAX_ENTRIES = 2'd0;
  localparam logic [1:0] REG_FILTER_MAC  = 2'd1;
  localparam logic [1:0] REG_CAP_MASK    = 2'd2;

  typedef struct packed {
    logic [63:0] key;
    logic [31:0] content;
    logic [32:0] expiry;
  } entry_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] key;
    logic [4:0]  slot;
  } event_t;
endpackage

>>> hdl/ntta_if.sv
// Channel interfaces of the neighbor table: item input and event output.
// Depends on nothing.
interface ntta_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [63:0] neighbor_key;
  logic [31:0] content_digest;
  logic [47:0] source_mac;
  logic [15:0] ttl_seconds;
  logic        has_caps;
  logic [15:0] enabled_caps;
  logic [31:0] now_time;
  modport source (output valid, command, neighbor_key, content_digest, source_mac,
                  ttl_seconds, has_caps, enabled_caps, now_time, input ready);
  modport sink (input valid, command, neighbor_key, content_digest, source_mac,
                ttl_seconds, has_caps, enabled_caps, now_time, output ready);
endinterface

interface ntta_event_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [63:0] event_key;
  logic [4:0]  event_slot;
  logic        last;
  modport source (output valid, event_kind, event_key, event_slot, last, input ready);
  modport sink (input valid, event_kind, event_key, event_slot, last, output ready);
endinterface

>>> hdl/ntta_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module ntta_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

>>> hdl/neighbor_table_ttl_aging.sv
// Top level of the neighbor table with TTL aging.
// Depends on ntta_pkg, ntta_if and ntta_ram.
//
// Usage: items enter on item_i (valid/ready), one at a time. A frame item
// looks up its key, then removes, refreshes, or (after eviction) inserts.
// An expire item evicts expired entries and trims to capacity. A flush item
// empties the table in the accept cycle and gives no events. Each event
// leaves on event_o as one transaction; last marks the final event of an item.
// The lookup is one pass over the entry RAM. Each eviction costs one
// min-expiry pass, and the final pass that finds nothing to evict costs
// the same. ready stays low while an item is in work.
// Reset empties the table (valid bits in flops, no clearing pass) and loads
// the register defaults. A stalled receiver holds the block in the current
// state; one event waits in a pending register and one in the output register.
// Config writes on cfg_we_i take effect at once. The user must make them only
// while idle; the block itself does not enforce this.
module neighbor_table_ttl_aging
  import ntta_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [47:0] cfg_data_i,
  ntta_item_if.sink   item_i,
  ntta_event_if.source event_o
);
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FIND   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_SPACE  = 3'd3;
  localparam logic [2:0] S_EVICT  = 3'd4;
  localparam logic [2:0] S_INSERT = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;

  logic [2:0] st_q, st_d;
  logic [5:0]  max_q;
  logic [47:0] fmac_q;
  logic [15:0] cmask_q;

  logic [1:0]  cmd_q;
  logic [63:0] key_q;
  logic [31:0] content_q;
  logic [47:0] src_q;
  logic [15:0] ttl_q;
  logic        hcaps_q;
  logic [15:0] caps_q;
  logic [31:0] now_q;

  logic [ENTRIES-1:0] valid_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [CNT_W-1:0]   scan_q;
  logic [SLOT_W-1:0]  chk_slot_q;
  logic               chk_vld_q;

  logic              found_q;
  logic [SLOT_W-1:0] found_slot_q;
  logic [31:0]       found_content_q;
  logic              had_old_q;

  logic              best_vld_q;
  logic [32:0]       best_exp_q;
  logic [SLOT_W-1:0] best_slot_q;
  logic [63:0]       best_key_q;

  logic   pend_vld_q;
  event_t pend_q;
  logic   ovld_q;
  event_t out_q;
  logic   olast_q;

  logic              rd_en, we;
  logic [SLOT_W-1:0] waddr;
  entry_t            wdata, rdata;
  logic              scan_done, hit, keep, out_free, can_emit, emit;
  event_t            ev;
  logic [CNT_W-1:0]  m, lim;
  logic [SLOT_W-1:0] free_slot;
  logic [32:0]       new_exp;

  ntta_ram #(.WIDTH($bits(entry_t)), .DEPTH(ENTRIES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (scan_q[SLOT_W-1:0]),
    .rdata_o (rdata)
  );

  assign new_exp   = {1'b0, now_q} + {17'd0, ttl_q};
  assign rd_en     = (st_q == S_FIND || st_q == S_SPACE) && scan_q < CNT_W'(ENTRIES);
  assign scan_done = chk_vld_q && chk_slot_q == SLOT_W'(ENTRIES - 1);
  assign hit       = chk_vld_q && valid_q[chk_slot_q] && rdata.key == key_q;
  assign keep      = ttl_q != 16'd0 && !(fmac_q != 48'd0 && fmac_q == src_q) &&
                     !(hcaps_q && (caps_q & cmask_q) == 16'd0);
  assign out_free  = !ovld_q || event_o.ready;
  assign can_emit  = !pend_vld_q || out_free;

  always_comb begin
    m = (max_q == 6'd0) ? CNT_W'(1) :
        ({26'd0, max_q} > ENTRIES) ? CNT_W'(ENTRIES) : CNT_W'(max_q);
    lim = (cmd_q == CMD_FRAME) ? m - CNT_W'(1) : m;
  end

  always_comb begin
    free_slot = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_slot = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    st_d  = st_q;
    emit  = 1'b0;
    ev    = '{kind: EV_REMOVED, key: key_q, slot: 5'(found_slot_q)};
    we    = 1'b0;
    waddr = found_slot_q;
    wdata = '{key: key_q, content: content_q, expiry: new_exp};
    case (st_q)
      S_IDLE: begin
        if (item_i.valid) begin
          if (item_i.command == CMD_FRAME) begin
            st_d = S_FIND;
          end else if (item_i.command == CMD_EXPIRE) begin
            st_d = S_SPACE;
          end
        end
      end
      S_FIND: begin
        if (scan_done) begin
          st_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!found_q) begin
          st_d = keep ? S_SPACE : S_FIN;
        end else if (keep && found_content_q != content_q) begin
          st_d = S_SPACE;
        end else if (can_emit) begin
          emit = 1'b1;
          if (keep) begin
            ev.kind = EV_REFRESHED;
            we      = 1'b1;
          end
          st_d = S_FIN;
        end
      end
      S_SPACE: begin
        if (scan_done) begin
          st_d = S_EVICT;
        end
      end
      S_EVICT: begin
        if (!best_vld_q || (cnt_q <= lim && best_exp_q > {1'b0, now_q})) begin
          st_d = (cmd_q == CMD_FRAME) ? S_INSERT : S_FIN;
        end else if (can_emit) begin
          emit = 1'b1;
          ev   = '{kind: EV_REMOVED, key: best_key_q, slot: 5'(best_slot_q)};
          st_d = S_SPACE;
        end
      end
      S_INSERT: begin
        if (can_emit) begin
          emit  = 1'b1;
          we    = 1'b1;
          waddr = free_slot;
          ev    = '{kind: had_old_q ? EV_UPDATED : EV_ADDED, key: key_q,
                    slot: 5'(free_slot)};
          st_d  = S_FIN;
        end
      end
      S_FIN: begin
        if (!pend_vld_q || out_free) begin
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && item_i.valid) begin
      cmd_q     <= item_i.command;
      key_q     <= item_i.neighbor_key;
      content_q <= item_i.content_digest;
      src_q     <= item_i.source_mac;
      ttl_q     <= item_i.ttl_seconds;
      hcaps_q   <= item_i.has_caps;
      caps_q    <= item_i.enabled_caps;
      now_q     <= item_i.now_time;
    end
    chk_slot_q <= scan_q[SLOT_W-1:0];
    if (hit && !found_q) begin
      found_slot_q    <= chk_slot_q;
      found_content_q <= rdata.content;
    end
    if (st_q == S_SPACE && chk_vld_q && valid_q[chk_slot_q] &&
        (!best_vld_q || rdata.expiry < best_exp_q)) begin
      best_exp_q  <= rdata.expiry;
      best_slot_q <= chk_slot_q;
      best_key_q  <= rdata.key;
    end
    if (emit) begin
      pend_q <= ev;
      if (pend_vld_q) begin
        out_q   <= pend_q;
        olast_q <= 1'b0;
      end
    end else if (st_q == S_FIN && pend_vld_q && out_free) begin
      out_q   <= pend_q;
      olast_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= S_IDLE;
      max_q      <= 6'd32;
      fmac_q     <= '0;
      cmask_q    <= 16'hFFFF;
      valid_q    <= '0;
      cnt_q      <= '0;
      scan_q     <= '0;
      chk_vld_q  <= 1'b0;
      found_q    <= 1'b0;
      had_old_q  <= 1'b0;
      best_vld_q <= 1'b0;
      pend_vld_q <= 1'b0;
      ovld_q     <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MAX_ENTRIES: max_q   <= cfg_data_i[5:0];
          REG_FILTER_MAC:  fmac_q  <= cfg_data_i;
          REG_CAP_MASK:    cmask_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      chk_vld_q <= rd_en;
      if (rd_en) begin
        scan_q <= scan_q + CNT_W'(1);
      end else if (st_q != S_FIND && st_q != S_SPACE) begin
        scan_q <= '0;
      end
      if (st_q == S_IDLE && item_i.valid) begin
        found_q   <= 1'b0;
        had_old_q <= 1'b0;
        if (item_i.command == CMD_FLUSH) begin
          valid_q <= '0;
          cnt_q   <= '0;
        end
      end
      if (hit) begin
        found_q <= 1'b1;
      end
      if (st_q == S_SPACE && chk_vld_q && valid_q[chk_slot_q] &&
          (!best_vld_q || rdata.expiry < best_exp_q)) begin
        best_vld_q <= 1'b1;
      end
      // best candidate lives until the next min-expiry pass starts
      if (st_q != S_SPACE && st_d == S_SPACE) begin
        best_vld_q <= 1'b0;
      end
      if (st_q == S_DECIDE && found_q && keep && found_content_q != content_q) begin
        valid_q[found_slot_q] <= 1'b0;
        cnt_q                 <= cnt_q - CNT_W'(1);
        had_old_q             <= 1'b1;
      end
      if (emit && st_q == S_DECIDE && !keep) begin
        valid_q[found_slot_q] <= 1'b0;
        cnt_q                 <= cnt_q - CNT_W'(1);
      end
      if (emit && st_q == S_EVICT) begin
        valid_q[best_slot_q] <= 1'b0;
        cnt_q                <= cnt_q - CNT_W'(1);
      end
      if (emit && st_q == S_INSERT) begin
        valid_q[free_slot] <= 1'b1;
        cnt_q              <= cnt_q + CNT_W'(1);
      end
      if (emit) begin
        pend_vld_q <= 1'b1;
        ovld_q     <= pend_vld_q | (ovld_q & ~event_o.ready);
      end else if (st_q == S_FIN && pend_vld_q && out_free) begin
        pend_vld_q <= 1'b0;
        ovld_q     <= 1'b1;
      end else if (event_o.ready) begin
        ovld_q <= 1'b0;
      end
    end
  end

  assign item_i.ready     = st_q == S_IDLE;
  assign event_o.valid    = ovld_q;
  assign event_o.event_kind = out_q.kind;
  assign event_o.event_key  = out_q.key;
  assign event_o.event_slot = out_q.slot;
  assign event_o.last       = olast_q;

  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == CNT_W'($countones(valid_q)))
    else $error("entry count differs from valid bits");
  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_IDLE |-> !pend_vld_q)
    else $error("event pending while idle");
  a_insert_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_INSERT |-> valid_q != {ENTRIES{1'b1}})
    else $error("insert with full table");
  a_emit_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && pend_vld_q |-> out_free)
    else $error("event overwrites busy output");
endmodule

>>> verif/ntta_checker.sv
`timescale 1ns / 1ps
// Checker for the neighbor table: watches item and event channels, predicts
// the event stream and compares it. Depends on ntta_pkg and ntta_if.
module ntta_checker
  import ntta_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [47:0] cfg_data_i,
  ntta_item_if        item_i,
  ntta_event_if       event_o,
  output int          errors_o,
  output int          pending_o
);
  typedef struct {
    logic [1:0]  kind;
    logic [63:0] key;
    logic [4:0]  slot;
    logic        last;
  } ev_s;

  logic        tbl_valid  [ENTRIES];
  logic [63:0] tbl_key    [ENTRIES];
  logic [31:0] tbl_content[ENTRIES];
  logic [32:0] tbl_expiry [ENTRIES];
  int          tbl_count;
  logic [5:0]  cap_reg;
  logic [47:0] filter_reg;
  logic [15:0] mask_reg;
  ev_s         events_due[$];

  assign pending_o = events_due.size();

  task automatic report(input string what);
    errors_o++;
    $display("%0t MISMATCH: %s", $realtime, what);
  endtask

  function automatic void push_ev(input logic [1:0] k, input int s);
    ev_s e;
    e.kind = k; e.key = tbl_key[s]; e.slot = s[4:0]; e.last = 1'b0;
    events_due.push_back(e);
  endfunction

  function automatic void evict(input int extra, input logic [32:0] now);
    int m, lim, best;
    m = (cap_reg < 1) ? 1 : (cap_reg > ENTRIES) ? ENTRIES : cap_reg;
    lim = (m > extra) ? m - extra : 0;
    forever begin
      best = -1;
      for (int i = 0; i < ENTRIES; i++)
        if (tbl_valid[i] && (best < 0 || tbl_expiry[i] < tbl_expiry[best])) best = i;
      if (best < 0) break;
      if (tbl_count <= lim && tbl_expiry[best] > now) break;
      tbl_valid[best] = 1'b0;
      if (tbl_count > 0) tbl_count--;
      push_ev(EV_REMOVED, best);
    end
  endfunction

  function automatic void predict();
    int n0, found;
    logic keep, had_old;
    logic [32:0] now, exp;
    n0 = events_due.size();
    now = {1'b0, item_i.now_time};
    exp = now + item_i.ttl_seconds;
    if (item_i.command == CMD_FLUSH) begin
      foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
      tbl_count = 0;
      return;
    end
    if (item_i.command == CMD_EXPIRE) begin
      evict(0, now);
    end else if (item_i.command == CMD_FRAME) begin
      keep = !(item_i.ttl_seconds == 0 ||
               (filter_reg != 0 && filter_reg == item_i.source_mac) ||
               (item_i.has_caps && (item_i.enabled_caps & mask_reg) == 0));
      had_old = 1'b0;
      found = -1;
      for (int i = 0; i < ENTRIES; i++)
        if (found < 0 && tbl_valid[i] && tbl_key[i] == item_i.neighbor_key) found = i;
      if (found >= 0 && !keep) begin
        tbl_valid[found] = 1'b0;
        if (tbl_count > 0) tbl_count--;
        push_ev(EV_REMOVED, found);
      end else if (found >= 0 && tbl_content[found] == item_i.content_digest) begin
        tbl_expiry[found] = exp;
        push_ev(EV_REFRESHED, found);
      end else if (found >= 0 || keep) begin
        if (found >= 0) begin
          tbl_valid[found] = 1'b0;
          if (tbl_count > 0) tbl_count--;
          had_old = 1'b1;
        end
        evict(1, now);
        found = -1;
        for (int i = 0; i < ENTRIES; i++)
          if (found < 0 && !tbl_valid[i]) found = i;
        if (found >= 0) begin
          tbl_valid[found] = 1'b1;
          tbl_key[found] = item_i.neighbor_key;
          tbl_content[found] = item_i.content_digest;
          tbl_expiry[found] = exp;
          tbl_count++;
          push_ev(had_old ? EV_UPDATED : EV_ADDED, found);
        end
      end
    end
    if (events_due.size() > n0) events_due[events_due.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ev_s e;
    if (!rst_ni) begin
      foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
      tbl_count = 0;
      cap_reg = 6'd32;
      filter_reg = '0;
      mask_reg = 16'hFFFF;
      events_due.delete();
      errors_o = 0;
    end else begin
      if (event_o.valid && event_o.ready) begin
        if (events_due.size() == 0) begin
          report($sformatf("unexpected event key %h", event_o.event_key));
        end else begin
          e = events_due.pop_front();
          if (event_o.event_kind !== e.kind)
            report($sformatf("kind %0d exp %0d", event_o.event_kind, e.kind));
          if (event_o.event_key !== e.key)
            report($sformatf("key %h exp %h", event_o.event_key, e.key));
          if (event_o.event_slot !== e.slot)
            report($sformatf("slot %0d exp %0d", event_o.event_slot, e.slot));
          if (event_o.last !== e.last)
            report($sformatf("last %b exp %b", event_o.last, e.last));
        end
      end
      if (item_i.valid && item_i.ready) predict();
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MAX_ENTRIES: cap_reg = cfg_data_i[5:0];
          REG_FILTER_MAC:  filter_reg = cfg_data_i;
          REG_CAP_MASK:    mask_reg = cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end
endmodule

>>> verif/tb_neighbor_table_ttl_aging.sv
`timescale 1ns / 1ps
// Testbench top for the neighbor table with TTL aging: drives items, config
// and output stalls, and gives the verdict. Depends on ntta_pkg, ntta_if,
// ntta_checker and the block.
module tb_neighbor_table_ttl_aging;
  import ntta_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = REG_MAX_ENTRIES;
  logic [47:0] cfg_data_i = '0;
  int          errors, pending;
  int          send_idle = 0, recv_stall = 0;
  logic        hold_off = 1'b0;
  int          quiet_cycles = 0;
  logic [31:0] clock_s = 32'd100;
  logic [63:0] keys[16];

  ntta_item_if  item_ch();
  ntta_event_if event_ch();

  neighbor_table_ttl_aging dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .item_i(item_ch), .event_o(event_ch)
  );

  ntta_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .item_i(item_ch), .event_o(event_ch), .errors_o(errors), .pending_o(pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    item_ch.valid = 1'b0;
    item_ch.command = CMD_FRAME;
    item_ch.neighbor_key = '0;
    item_ch.content_digest = '0;
    item_ch.source_mac = '0;
    item_ch.ttl_seconds = '0;
    item_ch.has_caps = 1'b0;
    item_ch.enabled_caps = '0;
    item_ch.now_time = '0;
    event_ch.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    if (hold_off)
      event_ch.ready <= 1'b0;
    else
      event_ch.ready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk_i) begin
    if ((item_ch.valid && item_ch.ready) || (event_ch.valid && event_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send(input logic [1:0] cmd, input logic [63:0] key,
                      input logic [31:0] dig, input logic [47:0] mac,
                      input logic [15:0] ttl, input logic hc,
                      input logic [15:0] caps, input logic [31:0] now);
    while ($urandom_range(99) < send_idle) begin
      item_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_ch.valid <= 1'b1;
    item_ch.command <= cmd;
    item_ch.neighbor_key <= key;
    item_ch.content_digest <= dig;
    item_ch.source_mac <= mac;
    item_ch.ttl_seconds <= ttl;
    item_ch.has_caps <= hc;
    item_ch.enabled_caps <= caps;
    item_ch.now_time <= now;
    do @(posedge clk_i); while (!item_ch.ready);
  endtask

  task automatic frame(input logic [63:0] key, input logic [31:0] dig,
                       input logic [15:0] ttl);
    send(CMD_FRAME, key, dig, 48'({$urandom, $urandom}), ttl, 1'($urandom_range(1)),
         16'($urandom), clock_s);
  endtask

  task automatic settle();
    item_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [47:0] val);
    settle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_items(input int count);
    logic [1:0] cmd;
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      clock_s = clock_s + $urandom_range(3);
      if (r < 3) begin
        clock_s = $urandom;
        send(CMD_FLUSH, {$urandom, $urandom}, $urandom, '0, '0, 1'b0, '0, clock_s);
      end else if (r < 5) begin
        cmd = 2'd3;
        send(cmd, {$urandom, $urandom}, $urandom, 48'({$urandom, $urandom}),
             16'($urandom), 1'($urandom_range(1)), 16'($urandom), $urandom);
      end else if (r < 15) begin
        send(CMD_EXPIRE, {$urandom, $urandom}, $urandom, '0, '0, 1'b0, '0, clock_s);
      end else if (r < 20) begin
        send(CMD_FRAME, {$urandom, $urandom}, $urandom, 48'({$urandom, $urandom}),
             16'($urandom), 1'($urandom_range(1)), 16'($urandom), $urandom);
      end else begin
        frame(keys[$urandom_range(15)], $urandom_range(2),
              ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(12)));
      end
    end
  endtask

  initial begin
    foreach (keys[i]) keys[i] = {$urandom, $urandom};
    keys[0] = '0;
    keys[1] = '1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: add, refresh, update, remove, drops, expire, flush
    frame(keys[0], 32'h0, 16'hFFFF);
    frame(keys[1], 32'hFFFF_FFFF, 16'd1);
    send(CMD_FRAME, keys[1], 32'hFFFF_FFFF, '1, 16'd5, 1'b1, 16'hFFFF, clock_s);
    send(CMD_FRAME, keys[1], 32'h1, '0, 16'd5, 1'b0, 16'h0, clock_s);
    send(CMD_FRAME, keys[1], 32'h1, '0, 16'd0, 1'b0, 16'h0, clock_s);
    send(CMD_FRAME, keys[2], 32'h1, '0, 16'd7, 1'b1, 16'h0, clock_s);
    send(CMD_FRAME, keys[2], 32'h1, '0, 16'd7, 1'b0, 16'h0, 32'hFFFF_FFFF);
    send(CMD_EXPIRE, '0, '0, '0, '0, 1'b0, '0, 32'hFFFF_FFFF);
    send(2'd3, '1, '1, '1, '1, 1'b1, '1, '1);
    for (int i = 3; i < 9; i++) frame(keys[i], i, 16'(i));
    send(CMD_FLUSH, '0, '0, '0, '0, 1'b0, '0, '0);
    send(CMD_EXPIRE, '0, '0, '0, '0, 1'b0, '0, clock_s);

    write_reg(REG_FILTER_MAC, 48'hFFFF_FFFF_FFFF);
    send(CMD_FRAME, keys[3], 32'h3, 48'hFFFF_FFFF_FFFF, 16'd9, 1'b0, '0, clock_s);
    write_reg(REG_CAP_MASK, 48'h0);
    send(CMD_FRAME, keys[4], 32'h4, '0, 16'd9, 1'b1, 16'hFFFF, clock_s);
    send(CMD_FRAME, keys[4], 32'h4, '0, 16'd9, 1'b0, 16'h0, clock_s);
    write_reg(REG_MAX_ENTRIES, 48'd0);
    frame(keys[5], 32'h5, 16'd9);
    send(CMD_EXPIRE, '0, '0, '0, '0, 1'b0, '0, clock_s);

    write_reg(REG_MAX_ENTRIES, 48'd3);
    write_reg(REG_FILTER_MAC, {$urandom, $urandom});
    write_reg(REG_CAP_MASK, 48'h1);
    random_items(60);
    send_idle = 83;
    write_reg(REG_MAX_ENTRIES, 48'd32);
    write_reg(REG_CAP_MASK, 48'hFFFF);
    random_items(50);
    send_idle = 0;
    recv_stall = 83;
    write_reg(REG_MAX_ENTRIES, 48'd63);
    write_reg(REG_FILTER_MAC, 48'h0);
    random_items(50);
    send_idle = 24;
    recv_stall = 24;
    write_reg(REG_MAX_ENTRIES, 48'd1);
    write_reg(REG_CAP_MASK, 48'h8001);
    random_items(50);

    send_idle = 0;
    recv_stall = 0;
    write_reg(REG_MAX_ENTRIES, 48'd2);
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(posedge clk_i);
        hold_off = 1'b0;
      end
      begin
        random_items(30);
        item_ch.valid <= 1'b0;
      end
    join

    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
